/* rtl/bctg_pkg.sv */
// Shared types and constants for the bounded concurrency task gate.
package bctg_pkg;

    // Task id width and in-flight counter width, fixed by the interface.
    localparam int ID_W  = 16;
    localparam int CNT_W = 6;

    // Most task starts that a single finish or enable request may cause.
    localparam int MAX_RESULTS = 32;

    // Command queue between the front and back parts.
    localparam int CMD_DEPTH = 2;
    localparam int CMD_AW    = 1;
    localparam int CMD_CW    = 2;

    // Request operations, encoded as the mode field.
    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_FINISH  = 2'd1,
        OP_ENABLE  = 2'd2,
        OP_DISABLE = 2'd3
    } t_op;

    // Result kinds.
    typedef enum logic [1:0] {
        K_START  = 2'd0,
        K_QUEUED = 2'd1,
        K_ACK    = 2'd2,
        K_DROP   = 2'd3
    } t_kind;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DRAIN = 2'd1,
        ST_EMIT  = 2'd2
    } t_state;

    // A classified request as it travels from the front to the back part.
    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] id;
    } t_cmd;

endpackage

/* rtl/bctg_front.sv */
// Front part: takes input requests and classifies them into commands.
module bctg_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_mode,
    input  logic [bctg_pkg::ID_W-1:0]         i_task_id,
    output logic                              o_push_valid,
    input  logic                              i_push_ready,
    output bctg_pkg::t_cmd                    o_push_cmd
);

    logic           r_valid;
    logic           n_valid;
    bctg_pkg::t_cmd r_cmd;
    bctg_pkg::t_cmd n_cmd;
    logic           accept;

    // The holding register frees when its command moves into the queue.
    assign o_ready      = !r_valid || i_push_ready;
    assign accept       = i_valid && o_ready;
    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

    // Decode the mode; only an add carries a task id.
    always_comb begin
        n_cmd = r_cmd;
        n_valid = r_valid && !i_push_ready;
        if (accept) begin
            n_valid = 1'b1;
            case (i_mode)
                bctg_pkg::OP_ADD: begin
                    n_cmd.op = bctg_pkg::OP_ADD;
                    n_cmd.id = i_task_id;
                end
                bctg_pkg::OP_FINISH: begin
                    n_cmd.op = bctg_pkg::OP_FINISH;
                    n_cmd.id = '0;
                end
                bctg_pkg::OP_ENABLE: begin
                    n_cmd.op = bctg_pkg::OP_ENABLE;
                    n_cmd.id = '0;
                end
                default: begin
                    n_cmd.op = bctg_pkg::OP_DISABLE;
                    n_cmd.id = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

/* rtl/bctg_cmd_fifo.sv */
// Short command queue that decouples the front part from the back part.
module bctg_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  bctg_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output bctg_pkg::t_cmd o_pop_cmd
);

    bctg_pkg::t_cmd                    r_entry [bctg_pkg::CMD_DEPTH];
    logic [bctg_pkg::CMD_AW-1:0]       r_wr_ptr;
    logic [bctg_pkg::CMD_AW-1:0]       r_rd_ptr;
    logic [bctg_pkg::CMD_CW-1:0]       r_count;
    logic                              push;
    logic                              pop;

    assign o_push_ready = (r_count != bctg_pkg::CMD_CW'(bctg_pkg::CMD_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers wrap at the queue depth; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == bctg_pkg::CMD_AW'(bctg_pkg::CMD_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == bctg_pkg::CMD_AW'(bctg_pkg::CMD_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

/* rtl/bctg_back.sv */
// Back part: gate state, wait queue memory and the result sequencer.
module bctg_back #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bctg_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  bctg_pkg::t_cmd                i_cmd,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_kind,
    output logic [bctg_pkg::ID_W-1:0]     o_task_id_res,
    output logic                          o_last,
    output logic                          o_idle,
    output logic [bctg_pkg::CNT_W-1:0]    o_in_flight
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int BW = $clog2(bctg_pkg::MAX_RESULTS + 1);

    // Wait queue memory and its read register.
    logic [bctg_pkg::ID_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [bctg_pkg::ID_W-1:0]  r_rd_data;

    // Gate state.
    bctg_pkg::t_state           r_state;
    bctg_pkg::t_state           n_state;
    logic [AW-1:0]              r_head;
    logic [AW-1:0]              n_head;
    logic [CW-1:0]              r_qcount;
    logic [CW-1:0]              n_qcount;
    logic [bctg_pkg::CNT_W-1:0] r_running;
    logic [bctg_pkg::CNT_W-1:0] n_running;
    logic                       r_gate;
    logic                       n_gate;
    logic [bctg_pkg::CNT_W-1:0] r_max;
    logic [BW-1:0]              r_burst;
    logic [BW-1:0]              n_burst;

    // Output register.
    logic                       r_out_valid;
    logic                       n_out_valid;
    bctg_pkg::t_kind            r_out_kind;
    bctg_pkg::t_kind            n_out_kind;
    logic [bctg_pkg::ID_W-1:0]  r_out_id;
    logic [bctg_pkg::ID_W-1:0]  n_out_id;
    logic                       r_out_last;
    logic                       n_out_last;
    logic                       r_out_idle;
    logic                       n_out_idle;
    logic [bctg_pkg::CNT_W-1:0] r_out_run;
    logic [bctg_pkg::CNT_W-1:0] n_out_run;

    logic                       out_free;
    logic                       below_max;
    logic                       can_start;
    logic                       more_after;
    logic                       q_full;
    logic [SW-1:0]              tail_sum;
    logic [AW-1:0]              tail;
    logic                       mem_we;
    logic [AW-1:0]              head_inc;

    assign out_free  = !r_out_valid || i_ready;
    assign below_max = (r_running < r_max);
    assign q_full    = (r_qcount == CW'(QUEUE_DEPTH));

    // Another start is allowed now, and would still be after the next one.
    assign can_start = r_gate && (r_qcount != '0) && below_max &&
                       (r_burst < BW'(bctg_pkg::MAX_RESULTS));
    assign more_after = r_gate && (r_qcount > CW'(1)) &&
                        (({1'b0, r_running} + 1'b1) < {1'b0, r_max}) &&
                        (r_burst < BW'(bctg_pkg::MAX_RESULTS - 1));

    // Tail slot is head plus count, wrapped once at the queue depth.
    assign tail_sum = SW'(r_head) + SW'(r_qcount);
    assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - SW'(QUEUE_DEPTH)) : AW'(tail_sum);
    assign head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_task_id_res = r_out_id;
    assign o_last        = r_out_last;
    assign o_idle        = r_out_idle;
    assign o_in_flight   = r_out_run;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bctg_pkg::ST_IDLE: begin
                if (i_cmd_valid && out_free &&
                    (i_cmd.op == bctg_pkg::OP_FINISH || i_cmd.op == bctg_pkg::OP_ENABLE)) begin
                    n_state = bctg_pkg::ST_DRAIN;
                end
            end
            bctg_pkg::ST_DRAIN: begin
                if (can_start) begin
                    n_state = bctg_pkg::ST_EMIT;
                end else if (out_free) begin
                    n_state = bctg_pkg::ST_IDLE;
                end
            end
            bctg_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = more_after ? bctg_pkg::ST_DRAIN : bctg_pkg::ST_IDLE;
                end
            end
            default: n_state = bctg_pkg::ST_IDLE;
        endcase
    end

    // Datapath and result generation for each state.
    always_comb begin
        n_head      = r_head;
        n_qcount    = r_qcount;
        n_running   = r_running;
        n_gate      = r_gate;
        n_burst     = r_burst;
        n_out_valid = r_out_valid && !i_ready;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_last  = r_out_last;
        n_out_idle  = r_out_idle;
        n_out_run   = r_out_run;
        o_cmd_ready = 1'b0;
        mem_we      = 1'b0;
        case (r_state)
            bctg_pkg::ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_ready = 1'b1;
                    case (i_cmd.op)
                        bctg_pkg::OP_ADD: begin
                            n_out_valid = 1'b1;
                            n_out_id    = i_cmd.id;
                            n_out_last  = 1'b1;
                            if (r_gate && below_max) begin
                                n_running  = r_running + 1'b1;
                                n_out_kind = bctg_pkg::K_START;
                            end else if (!q_full) begin
                                mem_we     = 1'b1;
                                n_qcount   = r_qcount + 1'b1;
                                n_out_kind = bctg_pkg::K_QUEUED;
                            end else begin
                                n_out_kind = bctg_pkg::K_DROP;
                            end
                            n_out_idle = (n_running == '0) && (n_qcount == '0);
                            n_out_run  = n_running;
                        end
                        bctg_pkg::OP_FINISH: begin
                            if (r_running != '0) begin
                                n_running = r_running - 1'b1;
                            end
                            n_burst = '0;
                        end
                        bctg_pkg::OP_ENABLE: begin
                            n_gate  = 1'b1;
                            n_burst = '0;
                        end
                        default: begin
                            n_gate      = 1'b0;
                            n_out_valid = 1'b1;
                            n_out_kind  = bctg_pkg::K_ACK;
                            n_out_id    = '0;
                            n_out_last  = 1'b1;
                            n_out_idle  = (r_running == '0) && (r_qcount == '0);
                            n_out_run   = r_running;
                        end
                    endcase
                end
            end
            bctg_pkg::ST_DRAIN: begin
                // Nothing could start: acknowledge the request instead.
                if (!can_start && out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = bctg_pkg::K_ACK;
                    n_out_id    = '0;
                    n_out_last  = 1'b1;
                    n_out_idle  = (r_running == '0) && (r_qcount == '0);
                    n_out_run   = r_running;
                end
            end
            bctg_pkg::ST_EMIT: begin
                // Start the oldest waiting task read out in the previous cycle.
                if (out_free) begin
                    n_head      = head_inc;
                    n_qcount    = r_qcount - 1'b1;
                    n_running   = r_running + 1'b1;
                    n_burst     = r_burst + 1'b1;
                    n_out_valid = 1'b1;
                    n_out_kind  = bctg_pkg::K_START;
                    n_out_id    = r_rd_data;
                    n_out_last  = !more_after;
                    n_out_idle  = (n_running == '0) && (n_qcount == '0);
                    n_out_run   = n_running;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers and the limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bctg_pkg::ST_IDLE;
            r_head      <= '0;
            r_qcount    <= '0;
            r_running   <= '0;
            r_gate      <= 1'b0;
            r_burst     <= '0;
            r_out_valid <= 1'b0;
            r_max       <= bctg_pkg::CNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_qcount    <= n_qcount;
            r_running   <= n_running;
            r_gate      <= n_gate;
            r_burst     <= n_burst;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
        r_out_idle <= n_out_idle;
        r_out_run  <= n_out_run;
    end

    // Wait queue memory: one write port at the tail, one registered read at the head.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[tail] <= i_cmd.id;
        end
        r_rd_data <= r_mem[r_head];
    end

`ifndef NO_ASSERTIONS
    a_qcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcount <= CW'(QUEUE_DEPTH))
        else $error("wait queue count exceeds its depth");

    a_emit_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bctg_pkg::ST_EMIT) |-> (r_qcount != '0) && r_gate)
        else $error("start issued with an empty queue or closed gate");

    a_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst <= BW'(bctg_pkg::MAX_RESULTS))
        else $error("start burst exceeds its limit");

    a_last_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bctg_pkg::ST_EMIT && out_free && n_state == bctg_pkg::ST_IDLE)
        |=> r_out_valid && r_out_last)
        else $error("final start of a burst not marked last");
`endif

endmodule

/* rtl/bounded_concurrency_task_gate.sv */
// Top level of the bounded concurrency task gate.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_ready    i_mode, i_task_id
//   result    out        o_valid / i_ready    o_kind, o_task_id_res, o_last, o_idle, o_in_flight
//   config    in         i_cfg_we             i_cfg_data (max_in_flight)
//
// A request passes a front register and a two-entry command queue to the back
// sequencer, which registers its answer to an add or disable as it takes it.
// Each task started by a finish or enable passes the DRAIN and EMIT states, as the
// wait queue memory read is registered; a request that starts nothing is acknowledged
// from DRAIN. Reset is synchronous and clears all control state; the wait queue
// memory needs no clearing pass. A stalled result register holds the sequencer; the queue fills.
module bounded_concurrency_task_gate #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic [bctg_pkg::ID_W-1:0]     i_task_id,
    input  logic                          i_cfg_we,
    input  logic [bctg_pkg::CNT_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_kind,
    output logic [bctg_pkg::ID_W-1:0]     o_task_id_res,
    output logic                          o_last,
    output logic                          o_idle,
    output logic [bctg_pkg::CNT_W-1:0]    o_in_flight
);

    logic           push_valid;
    logic           push_ready;
    bctg_pkg::t_cmd push_cmd;
    logic           cmd_valid;
    logic           cmd_ready;
    bctg_pkg::t_cmd cmd;

    // Front part: request register and mode decode.
    bctg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_task_id    (i_task_id),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    // Command queue between the two parts.
    bctg_cmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (cmd_valid),
        .i_pop_ready  (cmd_ready),
        .o_pop_cmd    (cmd)
    );

    // Back part: gate state, wait queue and results.
    bctg_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_ready   (cmd_ready),
        .i_cmd         (cmd),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_task_id_res (o_task_id_res),
        .o_last        (o_last),
        .o_idle        (o_idle),
        .o_in_flight   (o_in_flight)
    );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the bounded concurrency task gate.
module tb;

    localparam int WAIT_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 2000000;

    // Receiver stall patterns.
    localparam int READY_ALWAYS   = 0;
    localparam int READY_RANDOM   = 1;
    localparam int READY_PERIODIC = 2;
    localparam int READY_BURSTY   = 3;

    // One result as the gate reports it.
    typedef struct packed {
        bctg_pkg::t_kind                kind;
        logic [bctg_pkg::ID_W-1:0]      id;
        logic                           last;
        logic                           idle;
        logic [bctg_pkg::CNT_W-1:0]     in_flight;
    } t_gate_result;

    // Predicts the gate's results and checks them in order of arrival.
    class t_task_gate_scoreboard;
        int unsigned               limit_setting;
        bit                        gate_enabled;
        int unsigned               running_tasks;
        logic [bctg_pkg::ID_W-1:0] waiting_ids[$];
        t_gate_result              expected_results[$];
        int                        error_count;

        function new();
            limit_setting = 1;
            gate_enabled  = 0;
            running_tasks = 0;
            error_count   = 0;
        endfunction

        function void set_limit(int unsigned value);
            limit_setting = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Appends one result with the counts as they stand now.
        function void add_expected(bctg_pkg::t_kind kind, logic [bctg_pkg::ID_W-1:0] id);
            t_gate_result r;
            r.kind      = kind;
            r.id        = id;
            r.last      = 1'b0;
            r.idle      = (running_tasks == 0 && waiting_ids.size() == 0);
            r.in_flight = running_tasks[bctg_pkg::CNT_W-1:0];
            expected_results.insert(expected_results.size(), r);
        endfunction

        // Works out every result that one accepted request causes.
        function void note_request(bctg_pkg::t_op op, logic [bctg_pkg::ID_W-1:0] id);
            int started;
            logic [bctg_pkg::ID_W-1:0] next_id;
            started = 0;
            case (op)
                bctg_pkg::OP_ADD: begin
                    if (gate_enabled && running_tasks < limit_setting) begin
                        running_tasks++;
                        add_expected(bctg_pkg::K_START, id);
                    end else if (waiting_ids.size() < WAIT_DEPTH) begin
                        waiting_ids.insert(waiting_ids.size(), id);
                        add_expected(bctg_pkg::K_QUEUED, id);
                    end else begin
                        add_expected(bctg_pkg::K_DROP, id);
                    end
                end
                bctg_pkg::OP_FINISH, bctg_pkg::OP_ENABLE: begin
                    if (op == bctg_pkg::OP_FINISH) begin
                        if (running_tasks > 0)
                            running_tasks--;
                    end else begin
                        gate_enabled = 1;
                    end
                    // Start waiting tasks in order while the limit allows.
                    while (gate_enabled && waiting_ids.size() > 0 &&
                           running_tasks < limit_setting &&
                           started < bctg_pkg::MAX_RESULTS) begin
                        next_id = waiting_ids[0];
                        waiting_ids.delete(0);
                        running_tasks++;
                        add_expected(bctg_pkg::K_START, next_id);
                        started++;
                    end
                    if (started == 0)
                        add_expected(bctg_pkg::K_ACK, '0);
                end
                default: begin
                    gate_enabled = 0;
                    add_expected(bctg_pkg::K_ACK, '0);
                end
            endcase
            expected_results[expected_results.size() - 1].last = 1'b1;
        endfunction

        function void report_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                error_count++;
            end
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(t_gate_result act);
            t_gate_result exp_r;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d id %0d",
                         $time, act.kind, act.id);
                error_count++;
                return;
            end
            exp_r = expected_results[0];
            expected_results.delete(0);
            report_field("kind", exp_r.kind, act.kind);
            report_field("task_id_res", exp_r.id, act.id);
            report_field("last", exp_r.last, act.last);
            report_field("idle", exp_r.idle, act.idle);
            report_field("in_flight", exp_r.in_flight, act.in_flight);
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [1:0]                 i_mode = '0;
    logic [bctg_pkg::ID_W-1:0]  i_task_id = '0;
    logic                       i_cfg_we = 1'b0;
    logic [bctg_pkg::CNT_W-1:0] i_cfg_data = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [1:0]                 o_kind;
    logic [bctg_pkg::ID_W-1:0]  o_task_id_res;
    logic                       o_last;
    logic                       o_idle;
    logic [bctg_pkg::CNT_W-1:0] o_in_flight;

    t_task_gate_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int          ready_style = READY_ALWAYS;
    int          stall_left = 0;
    int          burst_max = 8;
    int          gap_max = 0;
    int          burst_left = 0;

    bounded_concurrency_task_gate i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_task_id     (i_task_id),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_task_id_res (o_task_id_res),
        .o_last        (o_last),
        .o_idle        (o_idle),
        .o_in_flight   (o_in_flight)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Receiver stalls: none, random, periodic, or occasional long stretches.
    always @(posedge i_clk) begin
        case (ready_style)
            READY_ALWAYS: i_ready <= 1'b1;
            READY_RANDOM: i_ready <= ($urandom_range(0, 9) < 7);
            READY_PERIODIC: i_ready <= ((cycle_count % 8) >= 3);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_ready <= 1'b0;
                end else if ($urandom_range(0, 19) == 0) begin
                    stall_left = $urandom_range(4, 15);
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        endcase
    end

    // Every accepted result goes to the scoreboard.
    always @(posedge i_clk) begin
        t_gate_result act;
        if (i_rst_n && o_valid && i_ready) begin
            act.kind      = bctg_pkg::t_kind'(o_kind);
            act.id        = o_task_id_res;
            act.last      = o_last;
            act.idle      = o_idle;
            act.in_flight = o_in_flight;
            sb.check_result(act);
        end
    end

    // Presents one request, waits for it to be taken, then maybe idles.
    task automatic send_request(bctg_pkg::t_op op, logic [bctg_pkg::ID_W-1:0] id);
        int gap;
        i_valid   <= 1'b1;
        i_mode    <= op;
        i_task_id <= id;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(op, id);
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            if (gap_max > 0)
                gap = $urandom_range(1, gap_max);
        end else begin
            burst_left--;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Changes the limit once the gate has delivered everything.
    task automatic write_limit(int unsigned value);
        wait_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[bctg_pkg::CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(value);
    endtask

    function automatic logic [bctg_pkg::ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return bctg_pkg::ID_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Random requests with the given percentages of add, finish and enable.
    task automatic run_phase(int count, int add_pct, int finish_pct, int enable_pct);
        int            r;
        bctg_pkg::t_op op;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct)
                op = bctg_pkg::OP_ADD;
            else if (r < add_pct + finish_pct)
                op = bctg_pkg::OP_FINISH;
            else if (r < add_pct + finish_pct + enable_pct)
                op = bctg_pkg::OP_ENABLE;
            else
                op = bctg_pkg::OP_DISABLE;
            send_request(op, pick_id());
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset limit of one and the gate closed.
        send_request(bctg_pkg::OP_ADD, 16'h0000);
        send_request(bctg_pkg::OP_ADD, 16'hFFFF);
        send_request(bctg_pkg::OP_FINISH, 16'hA5A5);     // finish with nothing running
        send_request(bctg_pkg::OP_DISABLE, 16'hFFFF);
        send_request(bctg_pkg::OP_ENABLE, 16'h5A5A);     // starts the oldest waiting task
        send_request(bctg_pkg::OP_ENABLE, 16'h0000);     // already at the limit
        send_request(bctg_pkg::OP_ADD, 16'h5555);
        send_request(bctg_pkg::OP_FINISH, 16'h0000);
        send_request(bctg_pkg::OP_FINISH, 16'hFFFF);
        send_request(bctg_pkg::OP_FINISH, 16'h1234);
        send_request(bctg_pkg::OP_FINISH, 16'h0000);     // count stays at zero
        send_request(bctg_pkg::OP_ADD, 16'hAAAA);        // starts at once
        send_request(bctg_pkg::OP_ADD, 16'h8001);
        send_request(bctg_pkg::OP_DISABLE, 16'h0000);
        send_request(bctg_pkg::OP_FINISH, 16'h0000);     // gate closed, task stays queued
        send_request(bctg_pkg::OP_ENABLE, 16'h0000);
        send_request(bctg_pkg::OP_FINISH, 16'h7FFE);

        // Limit of zero: the queue fills and further adds are dropped.
        gap_max = 4; burst_max = 10; ready_style = READY_RANDOM;
        write_limit(0);
        run_phase(50, 75, 8, 9);

        // Full limit: one enable releases the whole queue in one burst.
        gap_max = 0; ready_style = READY_BURSTY;
        write_limit(32);
        send_request(bctg_pkg::OP_ENABLE, pick_id());
        run_phase(45, 55, 25, 10);

        // Limit lowered under the running count.
        gap_max = 6; burst_max = 4; ready_style = READY_PERIODIC;
        write_limit(3);
        run_phase(45, 45, 35, 10);

        gap_max = 3; burst_max = 12; ready_style = READY_ALWAYS;
        write_limit(31);
        run_phase(45, 60, 20, 10);

        gap_max = 0; ready_style = READY_RANDOM;
        write_limit(1);
        run_phase(45, 45, 35, 12);

        gap_max = 5; burst_max = 6; ready_style = READY_BURSTY;
        write_limit(2);
        run_phase(45, 50, 30, 10);

        gap_max = 2; burst_max = 8; ready_style = READY_PERIODIC;
        write_limit(17);
        run_phase(45, 65, 15, 10);

        gap_max = 0; ready_style = READY_ALWAYS;
        write_limit(32);
        run_phase(45, 40, 40, 12);

        gap_max = 4; burst_max = 5; ready_style = READY_RANDOM;
        write_limit($urandom_range(4, 12));
        run_phase(45, 50, 30, 10);

        wait_results();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.error_count++;
        end
        if (sb.error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Ends a run that hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
rtl/bctg_pkg.sv
rtl/bctg_front.sv
rtl/bctg_cmd_fifo.sv
rtl/bctg_back.sv
rtl/bounded_concurrency_task_gate.sv
verif/tb.sv
